@@ hdl/hsv2rgb_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChanW = 8;
  localparam int unsigned RgbW  = 3 * ChanW;

  localparam logic [HueW-1:0] HueMax    = 9'd360;
  localparam logic [PctW-1:0] PctMax    = 7'd100;
  localparam logic [PctW-1:0] SectorDeg = 7'd60;

  // Shared multiplier geometry
  localparam int unsigned MulAW = 20;  // channel sums reach 600000
  localparam int unsigned MulBW = 24;  // reciprocal constant
  localparam int unsigned MulPW = 43;  // largest product used is below 2^43

  // floor(n * 255 / 600000) == (n * ScaleRecip) >> ScaleShift for n <= 600000
  localparam logic [MulBW-1:0] ScaleRecip = 24'd14602889;
  localparam int unsigned      ScaleShift = 35;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] saturation;
    logic [PctW-1:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             in_range;
  } rgb_out_t;

  // Top level to sequencer
  typedef struct packed {
    logic    start;
    hsv_in_t item;
  } seq_ctrl_t;

  // Sequencer to top level
  typedef struct packed {
    logic            done;
    logic [RgbW-1:0] rgb;
  } seq_stat_t;

endpackage

@@ hdl/hsv2rgb_mul.sv @@
// Shared multiplier with a registered product.
module hsv2rgb_mul (
  input  logic                            clk_i,
  input  logic [hsv2rgb_pkg::MulAW-1:0]   a_i,
  input  logic [hsv2rgb_pkg::MulBW-1:0]   b_i,
  output logic [hsv2rgb_pkg::MulPW-1:0]   prod_o
);
  import hsv2rgb_pkg::*;

  logic [MulAW+MulBW-1:0] full;
  logic [MulPW-1:0]       prod_q;

  assign full = a_i * b_i;

  // Register the product for the next step
  always_ff @(posedge clk_i) begin
    prod_q <= full[MulPW-1:0];
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/hsv2rgb_seq.sv @@
// Step sequencer that drives the shared multiplier through one conversion.
module hsv2rgb_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hsv2rgb_pkg::seq_ctrl_t ctrl_i,
  output hsv2rgb_pkg::seq_stat_t stat_o
);
  import hsv2rgb_pkg::*;

  localparam logic [3:0] StepSv    = 4'd0;
  localparam logic [3:0] StepVm    = 4'd1;
  localparam logic [3:0] StepM     = 4'd2;
  localparam logic [3:0] StepC     = 4'd3;
  localparam logic [3:0] StepX     = 4'd4;
  localparam logic [3:0] StepSum   = 4'd5;
  localparam logic [3:0] StepRed   = 4'd6;
  localparam logic [3:0] StepGreen = 4'd7;
  localparam logic [3:0] StepBlue  = 4'd8;
  localparam logic [3:0] StepLast  = 4'd9;

  logic             busy_q;
  logic [3:0]       step_q;
  logic [PctW-1:0]  sat_q, val_q;
  logic [2:0]       sector_q, sector_d;
  logic [5:0]       factor_q, factor_d;
  logic [HueW-1:0]  base;
  logic [6:0]       frac;
  logic [13:0]      sv_q;
  logic [MulAW-1:0] m_q, c_q, x_w;
  logic [MulAW-1:0] red_n_q, grn_n_q, blu_n_q;
  logic [MulAW-1:0] red_c, grn_c, blu_c;
  logic [ChanW-1:0] red_q, grn_q;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] prod;

  // Sector index by threshold compares, hue 360 lands in the last sector
  always_comb begin
    sector_d = 3'(ctrl_i.item.hue >= 9'd60)  + 3'(ctrl_i.item.hue >= 9'd120)
             + 3'(ctrl_i.item.hue >= 9'd180) + 3'(ctrl_i.item.hue >= 9'd240)
             + 3'(ctrl_i.item.hue >= 9'd300);
    unique case (sector_d)
      3'd0:    base = 9'd0;
      3'd1:    base = 9'd60;
      3'd2:    base = 9'd120;
      3'd3:    base = 9'd180;
      3'd4:    base = 9'd240;
      3'd5:    base = 9'd300;
      default: base = 9'd0;
    endcase
    frac = 7'(ctrl_i.item.hue - base);
    // Rising edge of X in even sectors, falling edge in odd ones
    factor_d = sector_d[0] ? 6'(SectorDeg - frac) : 6'(frac);
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepSv;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      step_q <= StepSv;
    end else if (busy_q) begin
      if (step_q == StepLast) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  // Choose multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      StepSv: begin
        mul_a = MulAW'(sat_q);
        mul_b = MulBW'(val_q);
      end
      StepVm: begin
        mul_a = MulAW'(val_q);
        mul_b = MulBW'(PctMax - sat_q);
      end
      StepM: begin
        mul_a = MulAW'(prod[13:0]);
        mul_b = MulBW'(SectorDeg);
      end
      StepC: begin
        mul_a = MulAW'(sv_q);
        mul_b = MulBW'(SectorDeg);
      end
      StepX: begin
        mul_a = MulAW'(sv_q);
        mul_b = MulBW'(factor_q);
      end
      StepRed: begin
        mul_a = red_n_q;
        mul_b = ScaleRecip;
      end
      StepGreen: begin
        mul_a = grn_n_q;
        mul_b = ScaleRecip;
      end
      StepBlue: begin
        mul_a = blu_n_q;
        mul_b = ScaleRecip;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hsv2rgb_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Place chroma and X on the channels for the sector
  assign x_w = prod[MulAW-1:0];

  always_comb begin
    unique case (sector_q)
      3'd0: begin red_c = c_q; grn_c = x_w; blu_c = '0;  end
      3'd1: begin red_c = x_w; grn_c = c_q; blu_c = '0;  end
      3'd2: begin red_c = '0;  grn_c = c_q; blu_c = x_w; end
      3'd3: begin red_c = '0;  grn_c = x_w; blu_c = c_q; end
      3'd4: begin red_c = x_w; grn_c = '0;  blu_c = c_q; end
      default: begin red_c = c_q; grn_c = '0; blu_c = x_w; end
    endcase
  end

  // Capture operands and step results
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      sat_q    <= ctrl_i.item.saturation;
      val_q    <= ctrl_i.item.brightness;
      sector_q <= sector_d;
      factor_q <= factor_d;
    end
    if (busy_q) begin
      case (step_q)
        StepVm:    sv_q    <= prod[13:0];
        StepC:     m_q     <= prod[MulAW-1:0];
        StepX:     c_q     <= prod[MulAW-1:0];
        StepSum: begin
          red_n_q <= red_c + m_q;
          grn_n_q <= grn_c + m_q;
          blu_n_q <= blu_c + m_q;
        end
        StepGreen: red_q   <= prod[ScaleShift+ChanW-1:ScaleShift];
        StepBlue:  grn_q   <= prod[ScaleShift+ChanW-1:ScaleShift];
        default: ;
      endcase
    end
  end

  assign stat_o.done = busy_q && (step_q == StepLast);
  assign stat_o.rgb  = {red_q, grn_q, prod[ScaleShift+ChanW-1:ScaleShift]};

endmodule

@@ hdl/hsv_to_rgb_converter_core.sv @@
// Top level of the HSV to RGB converter: handshakes, held colour, result register.
//
//   channel  | direction | payload               | handshake
//   ---------+-----------+-----------------------+------------------------
//   in       | input     | hsv_in_t  (23 bits)   | in_valid_i / in_stall_o
//   out      | output    | rgb_out_t (25 bits)   | out_valid_o / out_stall_i
//
// An in-range transaction is computed in ten sequencer steps around the one shared
// multiplier (two for S*V and V*(100-S), three for m, C and X, one add, three reciprocal
// scalings, one to collect the colour), then its result is registered and shown valid.
// An out-of-range one answers next cycle. One transaction is in flight at a time; the
// input is stalled until the result is taken.
// Reset clears the held colour to black and returns to idle.
module hsv_to_rgb_converter_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  hsv2rgb_pkg::hsv_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output hsv2rgb_pkg::rgb_out_t out_data_o
);
  import hsv2rgb_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [RgbW-1:0] held_q, held_d;
  rgb_out_t        out_q, out_d;
  logic            in_ok, in_take;
  seq_ctrl_t       seq_ctrl;
  seq_stat_t       seq_stat;

  assign in_ok   = (in_data_i.hue <= HueMax) && (in_data_i.saturation <= PctMax)
                && (in_data_i.brightness <= PctMax);
  assign in_take = (state_q == StIdle) && in_valid_i;

  assign seq_ctrl.start = in_take && in_ok;
  assign seq_ctrl.item  = in_data_i;

  hsv2rgb_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (seq_ctrl),
    .stat_o (seq_stat)
  );

  // Sequence one transaction at a time
  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    out_d   = out_q;
    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          if (in_ok) begin
            state_d = StCalc;
          end else begin
            out_d   = {held_q, 1'b0};
            state_d = StOut;
          end
        end
      end
      StCalc: begin
        if (seq_stat.done) begin
          held_d  = seq_stat.rgb;
          out_d   = {seq_stat.rgb, 1'b1};
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = out_q;

endmodule

@@ hdl/hsv2rgb_checker.sv @@
// Port-level assertions for the HSV to RGB converter, bound to the top level.
module hsv2rgb_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input hsv2rgb_pkg::hsv_in_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input hsv2rgb_pkg::rgb_out_t out_data_o
);
  import hsv2rgb_pkg::*;

  logic [RgbW-1:0] last_good_q;
  logic            in_acc, out_acc, in_bad;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_bad  = (in_data_i.hue > HueMax) || (in_data_i.saturation > PctMax)
                || (in_data_i.brightness > PctMax);

  // Track the last colour delivered with in_range set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_good_q <= '0;
    end else if (out_acc && out_data_o.in_range) begin
      last_good_q <= {out_data_o.red, out_data_o.green, out_data_o.blue};
    end
  end

  // A rejected transaction repeats the last good colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_range |->
      {out_data_o.red, out_data_o.green, out_data_o.blue} == last_good_q)
    else $error("held colour not repeated");

  // A rejected transaction answers on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_bad |=> out_valid_o && !out_data_o.in_range)
    else $error("rejected transaction not answered at once");

  // The input stays stalled once a transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("second transaction taken while busy");

  // A result is delivered once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> !out_valid_o)
    else $error("result repeated");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (.*);

@@ verif/hsv_to_rgb_converter_core_tb.sv @@
// Self-checking testbench for the HSV to RGB converter core.
module hsv_to_rgb_converter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int unsigned FullScale   = 255;
  localparam int unsigned UnitDen     = 600000;
  localparam int unsigned SettleWait  = 30;
  localparam int unsigned StuckLimit  = 5000;
  localparam int unsigned PhaseItems  = 220;

  // Hexcone sectors, 60 degrees each; hue 360 folds into the last one
  typedef enum int unsigned {
    SectRedYellow, SectYellowGreen, SectGreenCyan,
    SectCyanBlue, SectBlueMagenta, SectMagentaRed
  } sector_e;

  // Colour predictor and store of expected colours
  class colour_scoreboard;
    rgb_out_t        expected_q[$];
    logic [RgbW-1:0] held_rgb;
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     converted;

    function new();
      held_rgb   = '0;
      mismatches = 0;
      checked    = 0;
      converted  = 0;
    endfunction

    function logic [ChanW-1:0] scale_chan(int unsigned n);
      return ChanW'((n * FullScale) / UnitDen);
    endfunction

    // Predict the colour for one accepted transaction and queue it
    function void note_input(hsv_in_t it);
      int unsigned h, s, v, c, x, m, hm, hue_off;
      int unsigned r, g, b;
      sector_e     sect;
      rgb_out_t    res;
      h = it.hue;
      s = it.saturation;
      v = it.brightness;
      res.in_range = (h <= HueMax) && (s <= PctMax) && (v <= PctMax);
      if (res.in_range) begin
        c       = s * v * SectorDeg;
        hm      = h % (2 * SectorDeg);
        hue_off = (hm >= SectorDeg) ? (hm - SectorDeg) : (SectorDeg - hm);
        x       = s * v * (SectorDeg - hue_off);
        m       = SectorDeg * v * (PctMax - s);
        sect = (h / SectorDeg > 5) ? SectMagentaRed : sector_e'(h / SectorDeg);
        case (sect)
          SectRedYellow:   begin r = c; g = x; b = 0; end
          SectYellowGreen: begin r = x; g = c; b = 0; end
          SectGreenCyan:   begin r = 0; g = c; b = x; end
          SectCyanBlue:    begin r = 0; g = x; b = c; end
          SectBlueMagenta: begin r = x; g = 0; b = c; end
          default:         begin r = c; g = 0; b = x; end
        endcase
        held_rgb = {scale_chan(r + m), scale_chan(g + m), scale_chan(b + m)};
      end
      {res.red, res.green, res.blue} = held_rgb;
      expected_q.push_back(res);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest expected colour
    task check_result(rgb_out_t got);
      rgb_out_t want;
      if (expected_q.size() == 0) begin
        report("result with no transaction pending", 1, 0);
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (want.in_range) converted++;
        if (got.red !== want.red)           report("red", got.red, want.red);
        if (got.green !== want.green)       report("green", got.green, want.green);
        if (got.blue !== want.blue)         report("blue", got.blue, want.blue);
        if (got.in_range !== want.in_range) report("in_range", got.in_range, want.in_range);
      end
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  hsv_in_t  in_data_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  rgb_out_t out_data_o;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned stuck_cycles = 0;
  int unsigned sent         = 0;

  colour_scoreboard sb = new();

  hsv_to_rgb_converter_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Observe both channels, check results and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= StuckLimit) begin
        $display("timeout: no transaction for %0d cycles", StuckLimit);
        $display("hsv_to_rgb_converter_core_tb failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Offer one transaction, idling first at random, and hold it until taken
  task automatic send_hsv(int unsigned h, int unsigned s, int unsigned v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    in_data_i.hue        <= HueW'(h);
    in_data_i.saturation <= PctW'(s);
    in_data_i.brightness <= PctW'(v);
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // Mostly legal colours, some with one field out of range, some raw noise
  task automatic send_random(int unsigned count);
    int unsigned h, s, v, pick;
    repeat (count) begin
      pick = $urandom_range(99);
      h = $urandom_range(HueMax);
      s = $urandom_range(PctMax);
      v = $urandom_range(PctMax);
      if (pick < 10) begin
        h = $urandom_range(6) * SectorDeg;
        s = $urandom_range(1) * PctMax;
        v = $urandom_range(1) * PctMax;
      end else if (pick < 80) begin
        // legal values as drawn
      end else if (pick < 85) begin
        h = $urandom_range(511, HueMax + 1);
      end else if (pick < 90) begin
        s = $urandom_range(127, PctMax + 1);
      end else if (pick < 93) begin
        v = $urandom_range(127, PctMax + 1);
      end else begin
        h = $urandom_range(511);
        s = $urandom_range(127);
        v = $urandom_range(127);
      end
      send_hsv(h, s, v);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: held black after reset, sector edges, hue 360, range limits
    send_hsv(361, 50, 50);
    send_hsv(0, 100, 100);
    send_hsv(59, 100, 100);
    send_hsv(60, 100, 100);
    send_hsv(119, 100, 100);
    send_hsv(120, 100, 100);
    send_hsv(179, 100, 100);
    send_hsv(180, 100, 100);
    send_hsv(239, 100, 100);
    send_hsv(240, 100, 100);
    send_hsv(299, 100, 100);
    send_hsv(300, 100, 100);
    send_hsv(359, 100, 100);
    send_hsv(360, 100, 100);
    send_hsv(511, 127, 127);
    send_hsv(200, 0, 100);
    send_hsv(200, 101, 40);
    send_hsv(200, 0, 0);
    send_hsv(30, 40, 101);
    send_hsv(90, 127, 0);
    send_hsv(150, 1, 1);
    send_hsv(330, 99, 99);

    // Random phases with different pacing on each side
    send_random(PhaseItems);
    send_gap_pct <= 59;
    stall_pct    <= 0;
    send_random(PhaseItems);
    send_gap_pct <= 0;
    stall_pct    <= 59;
    send_random(PhaseItems);
    send_gap_pct <= 31;
    stall_pct    <= 31;
    send_random(PhaseItems);
    in_valid_i <= 1'b0;

    // Drain outstanding colours, then allow the pipeline to settle
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    stall_pct <= 0;
    repeat (SettleWait) @(posedge clk_i);

    while (sb.expected_q.size() != 0) begin
      void'(sb.expected_q.pop_front());
      sb.report("expected colour never delivered", 0, 1);
    end

    $display("Sent %0d colours; %0d results checked, %0d converted and %0d held.",
             sent, sb.checked, sb.converted, sb.checked - sb.converted);
    $display("Pacing covered free flow, sender gaps, result stalls and both together.");
    if (sb.mismatches == 0) begin
      $display("hsv_to_rgb_converter_core_tb passed");
    end else begin
      $display("hsv_to_rgb_converter_core_tb failed");
    end
    $finish;
  end

endmodule
